[rtl/rxs_pkg.sv]
// shared types and constants for the record exchange sorter
package rxs_pkg;

    localparam int ID_W     = 31;
    localparam int WEIGHT_W = 20;
    localparam int LIMIT_W  = 7;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SORT_DESC  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EMIT_LIMIT = 2'd1;

    typedef struct packed {
        logic [ID_W-1:0]     record_id;
        logic [WEIGHT_W-1:0] weight;
        logic                last_record;
    } t_in_word;

    typedef struct packed {
        logic [ID_W-1:0]     out_id;
        logic [WEIGHT_W-1:0] out_weight;
        logic                last_result;
        logic                overflow_seen;
    } t_out_word;

    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [WEIGHT_W-1:0] weight;
    } t_record;

    localparam int REC_W = $bits(t_record);

endpackage

[rtl/rxs_ram.sv]
// generic single write port ram with registered read
module rxs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/record_exchange_sorter.sv]
// record exchange sorter: load one record per word, sort by weight, emit the top records
// loading: words are taken only in the load state; after the last word the sort runs
//   one compare per cycle through one comparator and the single read port of the
//   record ram
// emission: the next result word is read out only after the previous one is taken
// reset: clears state, counts and config; r_cur, r_out and the record ram stay undefined
module record_exchange_sorter #(
    parameter int CAPACITY = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  rxs_pkg::t_in_word                i_in_word,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output rxs_pkg::t_out_word               o_out_word,
    input  logic                             i_cfg_we,
    input  logic [rxs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [rxs_pkg::LIMIT_W-1:0]      i_cfg_data
);

    import rxs_pkg::*;

    localparam int AW    = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    localparam logic [2:0] ST_LOAD   = 3'd0;
    localparam logic [2:0] ST_SORT_I = 3'd1;
    localparam logic [2:0] ST_RD_I   = 3'd2;
    localparam logic [2:0] ST_CMP    = 3'd3;
    localparam logic [2:0] ST_WB     = 3'd4;
    localparam logic [2:0] ST_EM_RD  = 3'd5;
    localparam logic [2:0] ST_EM_LD  = 3'd6;

    logic [2:0]         r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_ovf, n_ovf;
    logic [CNT_W-1:0]   r_i, n_i;
    logic [CNT_W-1:0]   r_j, n_j;
    logic [CNT_W-1:0]   r_k, n_k;
    logic [CNT_W-1:0]   r_emit_n, n_emit_n;
    t_record            r_cur, n_cur;
    logic               r_desc;
    logic [LIMIT_W-1:0] r_limit;
    logic               r_out_valid, n_out_valid;
    t_out_word          r_out, n_out;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    t_record            mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [REC_W-1:0]   mem_rdata;
    t_record            rd_rec;

    logic               in_acc;
    logic               swap;
    logic [WEIGHT_W-1:0] cmp_a, cmp_b;
    logic [CNT_W-1:0]   limited_n;
    logic [CNT_W-1:0]   j_next;

    assign rd_rec = t_record'(mem_rdata);

    rxs_ram #(
        .WIDTH(REC_W),
        .DEPTH(CAPACITY)
    ) u_rec_ram (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    assign o_in_ready  = (r_state == ST_LOAD);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // shared comparator: true when the held record must move behind the read one
    assign cmp_a = r_desc ? rd_rec.weight : r_cur.weight;
    assign cmp_b = r_desc ? r_cur.weight  : rd_rec.weight;
    assign swap  = cmp_a > cmp_b;

    assign j_next = r_j + CNT_W'(1);

    always_comb begin
        if ((r_limit != '0) && (r_limit < LIMIT_W'(r_count))) begin
            limited_n = r_limit[CNT_W-1:0];
        end else begin
            limited_n = r_count;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_emit_n    = r_emit_n;
        n_cur       = r_cur;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        mem_we      = 1'b0;
        mem_waddr   = r_count[AW-1:0];
        mem_wdata   = '{id: i_in_word.record_id, weight: i_in_word.weight};
        mem_raddr   = r_i[AW-1:0];

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_LOAD: begin
                if (in_acc) begin
                    if (r_count < CAP_CNT) begin
                        mem_we  = 1'b1;
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in_word.last_record) begin
                        n_i     = '0;
                        n_state = ST_SORT_I;
                    end
                end
            end
            ST_SORT_I: begin
                mem_raddr = r_i[AW-1:0];
                if ((r_i + CNT_W'(1)) >= r_count) begin
                    n_k      = '0;
                    n_emit_n = limited_n;
                    n_state  = ST_EM_RD;
                end else begin
                    n_state = ST_RD_I;
                end
            end
            ST_RD_I: begin
                n_cur     = rd_rec;
                n_j       = r_i + CNT_W'(1);
                mem_raddr = n_j[AW-1:0];
                n_state   = ST_CMP;
            end
            ST_CMP: begin
                mem_raddr = j_next[AW-1:0];
                if (swap) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_j[AW-1:0];
                    mem_wdata = r_cur;
                    n_cur     = rd_rec;
                end
                n_j = j_next;
                if (j_next == r_count) begin
                    n_state = ST_WB;
                end
            end
            ST_WB: begin
                mem_we    = 1'b1;
                mem_waddr = r_i[AW-1:0];
                mem_wdata = r_cur;
                n_i       = r_i + CNT_W'(1);
                n_state   = ST_SORT_I;
            end
            ST_EM_RD: begin
                mem_raddr = r_k[AW-1:0];
                if (!r_out_valid) begin
                    n_state = ST_EM_LD;
                end
            end
            ST_EM_LD: begin
                n_out_valid         = 1'b1;
                n_out.out_id        = rd_rec.id;
                n_out.out_weight    = rd_rec.weight;
                n_out.overflow_seen = r_ovf;
                n_out.last_result   = ((r_k + CNT_W'(1)) == r_emit_n);
                if ((r_k + CNT_W'(1)) == r_emit_n) begin
                    n_count = '0;
                    n_ovf   = 1'b0;
                    n_state = ST_LOAD;
                end else begin
                    n_k     = r_k + CNT_W'(1);
                    n_state = ST_EM_RD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_emit_n    <= '0;
            r_out_valid <= 1'b0;
            r_desc      <= 1'b0;
            r_limit     <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_i         <= n_i;
            r_j         <= n_j;
            r_k         <= n_k;
            r_emit_n    <= n_emit_n;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_SORT_DESC:  r_desc  <= i_cfg_data[0];
                    REG_EMIT_LIMIT: r_limit <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        r_out <= n_out;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_CNT)
        else $error("record count above capacity");

    a_no_write_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && (r_state == ST_LOAD)) |-> (r_count < CAP_CNT))
        else $error("ram write while set is full");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EM_LD && n_out.last_result) |=> (r_state == ST_LOAD && r_count == '0))
        else $error("run did not close after final word");

    a_emit_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EM_RD || r_state == ST_EM_LD) |-> (r_k < r_emit_n))
        else $error("emit index past emit count");

    a_last_starts_sort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_word.last_record) |=> (r_state == ST_SORT_I && r_i == '0))
        else $error("final word did not start sort");

endmodule

[bench/tb.sv]
// testbench for record_exchange_sorter: loads record sets, checks the sorted and limited output
module tb;
    import rxs_pkg::*;

    localparam int CAPACITY    = 64;
    localparam int STALL_LIMIT = 20000;
    localparam int BATCH_WORDS = 28;
    localparam int END_SETTLE  = 100;
    localparam int CFG_SETTLE  = 8;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    localparam logic [ID_W-1:0]     ID_MAX     = '1;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = '1;

    class sorted_run_checker;
        t_record           held[$];
        t_out_word         expected_results[$];
        bit                dropped;
        bit                descending;
        logic [LIMIT_W-1:0] limit;
        int                errors;
        int                words_seen;
        int                sets_seen;
        int                overflow_sets;
        int                results_checked;

        function new();
            dropped = 1'b0;
            descending = 1'b0;
            limit = '0;
            errors = 0;
            words_seen = 0;
            sets_seen = 0;
            overflow_sets = 0;
            results_checked = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [LIMIT_W-1:0] data);
            if (idx == REG_SORT_DESC) begin
                descending = data[0];
            end else if (idx == REG_EMIT_LIMIT) begin
                limit = data;
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void note_record(t_in_word w);
            t_record   rec;
            t_record   tmp;
            t_out_word res;
            int        n;
            bit        swap;
            words_seen++;
            if (held.size() < CAPACITY) begin
                rec.id = w.record_id;
                rec.weight = w.weight;
                held.push_back(rec);
            end else begin
                dropped = 1'b1;
            end
            if (!w.last_record) return;
            for (int i = 0; i + 1 < held.size(); i++) begin
                for (int j = i + 1; j < held.size(); j++) begin
                    swap = descending ? (held[i].weight < held[j].weight)
                                      : (held[i].weight > held[j].weight);
                    if (swap) begin
                        tmp = held[i];
                        held[i] = held[j];
                        held[j] = tmp;
                    end
                end
            end
            n = held.size();
            if (limit != 0 && int'(limit) < n) n = int'(limit);
            for (int k = 0; k < n; k++) begin
                res.out_id = held[k].id;
                res.out_weight = held[k].weight;
                res.last_result = (k + 1 == n);
                res.overflow_seen = dropped;
                expected_results.push_back(res);
            end
            sets_seen++;
            if (dropped) overflow_sets++;
            held.delete();
            dropped = 1'b0;
        endfunction

        function void check_emitted(t_out_word got);
            t_out_word want;
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected word id %h weight %h last %b ovf %b", $time,
                         got.out_id, got.out_weight, got.last_result, got.overflow_seen);
                return;
            end
            want = expected_results.pop_front();
            results_checked++;
            if (got !== want) begin
                errors++;
                $display("%0t: mismatch expected id %h weight %h last %b ovf %b", $time,
                         want.out_id, want.out_weight, want.last_result, want.overflow_seen);
                $display("%0t:          got      id %h weight %h last %b ovf %b", $time,
                         got.out_id, got.out_weight, got.last_result, got.overflow_seen);
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    t_in_word           i_in_word = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    t_out_word          o_out_word;
    logic               i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [LIMIT_W-1:0] i_cfg_data = '0;

    sorted_run_checker sb = new();

    int send_idle_pct = 37;
    int recv_idle_pct = 73;
    int send_calm = 0;
    int recv_calm = 0;
    int quiet_cycles = 0;
    bit spare_toggle = 1'b0;

    record_exchange_sorter #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_word(i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_word(o_out_word),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) sb.check_emitted(o_out_word);
            if (recv_calm > 0) begin
                recv_calm--;
                i_out_ready <= 1'b1;
            end else begin
                if ($urandom_range(99) < 3) recv_calm = $urandom_range(40, 8);
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_in_word make_word(logic [ID_W-1:0] id, logic [WEIGHT_W-1:0] w,
                                           logic last);
        t_in_word word;
        word.record_id = id;
        word.weight = w;
        word.last_record = last;
        return word;
    endfunction

    function automatic logic [ID_W-1:0] rand_id();
        int roll;
        roll = $urandom_range(99);
        if (roll < 5) return '0;
        if (roll < 10) return ID_MAX;
        return ID_W'($urandom());
    endfunction

    // narrow ranges give plenty of ties
    function automatic logic [WEIGHT_W-1:0] rand_weight();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10) return '0;
        if (roll < 20) return WEIGHT_MAX;
        if (roll < 50) return WEIGHT_W'($urandom_range(7));
        return WEIGHT_W'($urandom());
    endfunction

    task automatic send_word(input t_in_word w);
        while (send_calm == 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_record(w);
        if (send_calm > 0) send_calm--;
        else if ($urandom_range(99) < 3) send_calm = $urandom_range(40, 8);
    endtask

    task automatic send_random_set(input int size);
        for (int k = 0; k < size; k++) begin
            send_word(make_word(rand_id(), rand_weight(), k == size - 1));
        end
    endtask

    task automatic drain_results(input int settle);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic set_regs(input bit desc, input logic [LIMIT_W-1:0] lim);
        logic [LIMIT_W-1:0] desc_data;
        logic [LIMIT_W-1:0] junk;
        desc_data = {LIMIT_W{1'b0}};
        desc_data[LIMIT_W-1:1] = (LIMIT_W-1)'($urandom());
        desc_data[0] = desc;
        junk = LIMIT_W'($urandom());
        i_cfg_we <= 1'b1;
        i_cfg_idx <= REG_SORT_DESC;
        i_cfg_data <= desc_data;
        @(posedge i_clk);
        sb.write_reg(REG_SORT_DESC, desc_data);
        i_cfg_idx <= REG_EMIT_LIMIT;
        i_cfg_data <= lim;
        @(posedge i_clk);
        sb.write_reg(REG_EMIT_LIMIT, lim);
        // unmapped index must be ignored
        i_cfg_idx <= spare_toggle ? REG_SPARE_B : REG_SPARE_A;
        i_cfg_data <= junk;
        @(posedge i_clk);
        sb.write_reg(spare_toggle ? REG_SPARE_B : REG_SPARE_A, junk);
        spare_toggle = !spare_toggle;
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int batch_start;
        int set_size;
        int roll;
        bit desc;
        logic [LIMIT_W-1:0] lim;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values: ascending, emit all
        send_word(make_word('0, '0, 1'b1));
        send_word(make_word(ID_MAX, WEIGHT_MAX, 1'b0));
        send_word(make_word(31'd1, 20'd5, 1'b0));
        send_word(make_word(31'd2, 20'd5, 1'b0));
        send_word(make_word(31'd3, '0, 1'b0));
        send_word(make_word(31'd4, WEIGHT_MAX, 1'b0));
        send_word(make_word(31'd5, 20'd5, 1'b1));

        // three heaviest with ties
        drain_results(CFG_SETTLE);
        set_regs(1'b1, 7'd3);
        send_word(make_word(31'd10, 20'd100, 1'b0));
        send_word(make_word(31'd11, 20'd300, 1'b0));
        send_word(make_word(31'd12, 20'd300, 1'b0));
        send_word(make_word(31'd13, 20'd50, 1'b0));
        send_word(make_word(31'd14, 20'd300, 1'b1));

        // first minimum
        drain_results(CFG_SETTLE);
        set_regs(1'b0, 7'd1);
        send_word(make_word(31'd20, 20'd7, 1'b0));
        send_word(make_word(31'd21, 20'd2, 1'b0));
        send_word(make_word(31'd22, 20'd2, 1'b0));
        send_word(make_word(31'd23, 20'd9, 1'b1));

        // limit above count
        drain_results(CFG_SETTLE);
        set_regs(1'b0, 7'd70);
        send_word(make_word(31'h2AAAAAAA, WEIGHT_MAX, 1'b0));
        send_word(make_word(31'h55555555, '0, 1'b0));
        send_word(make_word(31'h0F0F0F0F, 20'h80000, 1'b1));

        for (int b = 0; b < 8; b++) begin
            drain_results(CFG_SETTLE);
            if (b < 3) begin
                send_idle_pct = 37;
                recv_idle_pct = 73;
            end else if (b < 6) begin
                send_idle_pct = 73;
                recv_idle_pct = 37;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (b)
                0: begin desc = 1'b0; lim = 7'd0; end
                1: begin desc = 1'b1; lim = 7'd3; end
                2: begin desc = 1'b0; lim = 7'd1; end
                3: begin desc = 1'b1; lim = 7'd64; end
                4: begin desc = 1'b0; lim = 7'd127; end
                5: begin desc = 1'b1; lim = 7'd0; end
                6: begin desc = 1'b0; lim = LIMIT_W'($urandom_range(8, 2)); end
                default: begin desc = 1'b1; lim = LIMIT_W'($urandom_range(126, 65)); end
            endcase
            set_regs(desc, lim);
            batch_start = sb.words_seen;
            // full store, one record dropped, several dropped
            if (b == 1) send_random_set(CAPACITY);
            if (b == 4) send_random_set(CAPACITY + 1);
            if (b == 7) send_random_set(CAPACITY + 6);
            while (sb.words_seen - batch_start < BATCH_WORDS) begin
                roll = $urandom_range(99);
                if (roll < 4) set_size = $urandom_range(70, 60);
                else if (roll < 20) set_size = $urandom_range(30, 11);
                else set_size = $urandom_range(10, 1);
                send_random_set(set_size);
                if ($urandom_range(9) == 0) drain_results(0);
            end
        end

        drain_results(END_SETTLE);
        if (sb.pending() != 0) $display("%0t: %0d results never arrived", $time, sb.pending());
        $display("covered %0d words in %0d sets (%0d with dropped records), %0d results checked",
                 sb.words_seen, sb.sets_seen, sb.overflow_sets, sb.results_checked);
        $display("both orders, limits 0 1 3 64 and above count, ties, full and overfull stores");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
